// ----- sv/cfd_pkg.sv -----
package cfd_pkg;

  localparam logic [31:0] HeaderPattern = 32'hAAEE_AAEE;
  localparam logic [31:0] DelimPattern  = 32'hAEAE_AEAE;
  localparam logic [31:0] CrcInit       = 32'hFFFF_FFFF;
  localparam logic [31:0] CrcPoly       = 32'hEDB8_8320;
  localparam logic [15:0] LengthExpect  = 16'h0001;
  localparam logic [7:0]  BroadcastId   = 8'h00;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = 1;
  localparam int unsigned QueueCntW  = 2;

  // Field positions within one frame.
  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_COMMAND = 3'd1,
    PH_LENGTH  = 3'd2,
    PH_ID      = 3'd3,
    PH_CHECK   = 3'd4,
    PH_DELIM   = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_TRIGGER = 2'd1,
    ACT_RESET   = 2'd2,
    ACT_ACK     = 2'd3
  } action_e;

  localparam logic [7:0] CmdTrigger = 8'd0;
  localparam logic [7:0] CmdReset   = 8'd1;
  localparam logic [7:0] CmdQuery   = 8'd2;

  // One completed frame, handed from the assembler to the decision stage.
  typedef struct packed {
    logic       frame_valid;
    logic [7:0] command;
    logic [7:0] target_id;
  } frame_rec_t;

  // Reflected CRC-32 update by one byte.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h000000, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  // Place a byte at its position; the first byte replaces the word.
  function automatic logic [31:0] merge32(input logic [31:0] word, input logic [7:0] b,
                                          input logic [1:0] pos);
    logic [31:0] part;
    part = {24'h000000, b} << {pos, 3'b000};
    return (pos == 2'd0) ? part : (word | part);
  endfunction

endpackage

// ----- sv/cfd_front.sv -----
module cfd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              byte_valid_i,
  output logic              byte_ready_o,
  input  logic [7:0]        byte_i,
  output logic              push_o,
  output cfd_pkg::frame_rec_t rec_o,
  input  logic              q_full_i
);

  cfd_pkg::phase_e phase_q, phase_d;
  logic [1:0]  idx_q, idx_d;
  logic [31:0] header_q, header_d;
  logic [7:0]  command_q, command_d;
  logic [15:0] length_q, length_d;
  logic [7:0]  id_q, id_d;
  logic [31:0] check_q, check_d;
  logic [31:0] crc_q, crc_d;
  logic [31:0] delim_next;
  logic        take;
  logic        last_byte;
  logic        done;

  assign byte_ready_o = !q_full_i;
  assign take         = byte_valid_i && byte_ready_o;
  assign delim_next   = cfd_pkg::merge32(32'h0, byte_i, idx_q);

  always_comb begin
    phase_d   = phase_q;
    idx_d     = idx_q;
    header_d  = header_q;
    command_d = command_q;
    length_d  = length_q;
    id_d      = id_q;
    check_d   = check_q;
    crc_d     = crc_q;
    last_byte = 1'b0;
    done      = 1'b0;
    if (take) begin
      unique case (phase_q)
        cfd_pkg::PH_HEADER: begin
          header_d  = cfd_pkg::merge32(header_q, byte_i, idx_q);
          last_byte = (idx_q == 2'd3);
        end
        cfd_pkg::PH_COMMAND: begin
          command_d = byte_i;
          last_byte = 1'b1;
        end
        cfd_pkg::PH_LENGTH: begin
          length_d  = (idx_q == 2'd0) ? {byte_i, 8'h00} : (length_q | {8'h00, byte_i});
          last_byte = (idx_q == 2'd1);
        end
        cfd_pkg::PH_ID: begin
          id_d      = byte_i;
          last_byte = 1'b1;
        end
        cfd_pkg::PH_CHECK: begin
          check_d   = cfd_pkg::merge32(check_q, byte_i, idx_q);
          last_byte = (idx_q == 2'd3);
        end
        cfd_pkg::PH_DELIM: begin
          last_byte = (idx_q == 2'd3);
          done      = last_byte;
        end
        default: begin
          // Unreachable phase: drop the byte and restart.
          phase_d = cfd_pkg::PH_HEADER;
          idx_d   = 2'd0;
        end
      endcase
      if (phase_q == cfd_pkg::PH_HEADER || phase_q == cfd_pkg::PH_COMMAND ||
          phase_q == cfd_pkg::PH_LENGTH || phase_q == cfd_pkg::PH_ID) begin
        crc_d = cfd_pkg::crc_byte(crc_q, byte_i);
      end
      if (phase_q == cfd_pkg::PH_HEADER || phase_q == cfd_pkg::PH_COMMAND ||
          phase_q == cfd_pkg::PH_LENGTH || phase_q == cfd_pkg::PH_ID ||
          phase_q == cfd_pkg::PH_CHECK || phase_q == cfd_pkg::PH_DELIM) begin
        if (last_byte) begin
          idx_d   = 2'd0;
          phase_d = done ? cfd_pkg::PH_HEADER : cfd_pkg::phase_e'(phase_q + 3'd1);
        end else begin
          idx_d = idx_q + 2'd1;
        end
      end
      if (done) begin
        crc_d = cfd_pkg::CrcInit;
      end
    end
  end

  // The delimiter is only ever needed whole, on its last byte.
  logic [31:0] delim_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= cfd_pkg::PH_HEADER;
      idx_q   <= 2'd0;
      crc_q   <= cfd_pkg::CrcInit;
    end else begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      crc_q   <= crc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    header_q  <= header_d;
    command_q <= command_d;
    length_q  <= length_d;
    id_q      <= id_d;
    check_q   <= check_d;
    if (take && phase_q == cfd_pkg::PH_DELIM) begin
      delim_q <= (idx_q == 2'd0) ? delim_next : (delim_q | delim_next);
    end
  end

  assign push_o = done;
  assign rec_o.frame_valid = (header_q == cfd_pkg::HeaderPattern) &&
                             ((delim_q | delim_next) == cfd_pkg::DelimPattern) &&
                             (length_q == cfd_pkg::LengthExpect) &&
                             (check_q == ~crc_q);
  assign rec_o.command   = command_q;
  assign rec_o.target_id = id_q;

  a_idx_in_multibyte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idx_q != 2'd0) |-> (phase_q == cfd_pkg::PH_HEADER || phase_q == cfd_pkg::PH_LENGTH ||
                         phase_q == cfd_pkg::PH_CHECK || phase_q == cfd_pkg::PH_DELIM))
    else $error("byte index advanced inside a one-byte field");

endmodule

// ----- sv/cfd_queue.sv -----
module cfd_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  cfd_pkg::frame_rec_t push_data_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output cfd_pkg::frame_rec_t pop_data_o
);

  cfd_pkg::frame_rec_t mem_q [cfd_pkg::QueueDepth];
  logic [cfd_pkg::QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [cfd_pkg::QueueCntW-1:0] count_q;
  logic do_pop;

  assign full_o     = (count_q == cfd_pkg::QueueCntW'(cfd_pkg::QueueDepth));
  assign valid_o    = (count_q != '0);
  assign do_pop     = pop_i && valid_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_q + cfd_pkg::QueueCntW'(push_i) - cfd_pkg::QueueCntW'(do_pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("frame pushed into a full queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cfd_pkg::QueueCntW'(cfd_pkg::QueueDepth))
    else $error("queue count beyond depth");

endmodule

// ----- sv/cfd_back.sv -----
module cfd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          node_id_i,
  input  logic                q_valid_i,
  input  cfd_pkg::frame_rec_t q_data_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output cfd_pkg::action_e    action_o,
  output logic                frame_valid_o,
  output logic [7:0]          command_o,
  output logic [7:0]          target_id_o
);

  logic             out_valid_q;
  cfd_pkg::action_e action_q, action_d;
  logic             fv_q;
  logic [7:0]       cmd_q, id_q;
  logic             to_me, to_me_or_all;

  assign pop_o        = q_valid_i && (!out_valid_q || out_ready_i);
  assign to_me        = (q_data_i.target_id == node_id_i);
  assign to_me_or_all = to_me || (q_data_i.target_id == cfd_pkg::BroadcastId);

  always_comb begin
    action_d = cfd_pkg::ACT_NONE;
    if (q_data_i.frame_valid) begin
      if (q_data_i.command == cfd_pkg::CmdTrigger && to_me_or_all) begin
        action_d = cfd_pkg::ACT_TRIGGER;
      end else if (q_data_i.command == cfd_pkg::CmdReset && to_me_or_all) begin
        action_d = cfd_pkg::ACT_RESET;
      end else if (q_data_i.command == cfd_pkg::CmdQuery && to_me) begin
        action_d = cfd_pkg::ACT_ACK;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      action_q <= action_d;
      fv_q     <= q_data_i.frame_valid;
      cmd_q    <= q_data_i.command;
      id_q     <= q_data_i.target_id;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign action_o      = action_q;
  assign frame_valid_o = fv_q;
  assign command_o     = cmd_q;
  assign target_id_o   = id_q;

  a_action_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !fv_q) |-> (action_q == cfd_pkg::ACT_NONE))
    else $error("action issued for a rejected frame");

endmodule

// ----- sv/control_frame_deframer_crc32_top.sv -----
// Channel    | Direction | Payload                                  | Accepted when
// s_axis     | in        | tdata[7:0] rx_byte                       | tvalid & tready
// m_axis     | out       | tdata action/command/target_id, tuser fv | tvalid & tready
// cfg        | in        | cfg_data_i[7:0] node_id                  | cfg_valid_i & cfg_ready_o
//
// One received byte per cycle while s_axis_tready_o is high; a completed frame is pushed
// into a two-entry frame queue at the edge that accepts its sixteenth byte, and
// m_axis_tvalid_o rises once the output register has taken it from the queue.
// s_axis_tready_o drops only while the frame queue holds two results, i.e. with a
// stalled result in the output register and two more completed frames behind it.
// Reset clears byte position, field phase, CRC, queue and output valid;
// node_id resets to zero. cfg_ready_o is always high.
module control_frame_deframer_crc32_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Byte stream in.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  // Frame results out.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [1:0] action, [9:2] command,
                                        // [17:10] target_id, [23:18] zero
  output logic        m_axis_tuser_o,   // [0] frame_valid
  // Node address register.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i
);

  logic [7:0]           node_id_q;
  logic                 push;
  logic                 q_full;
  logic                 q_valid;
  logic                 pop;
  cfd_pkg::frame_rec_t  rec_in, rec_out;
  cfd_pkg::action_e     action;
  logic                 frame_valid;
  logic [7:0]           command;
  logic [7:0]           target_id;

  assign cfg_ready_o = 1'b1;

  // Hold the node address; write it only while the block is quiet (not enforced here).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_id_q <= 8'h00;
    end else if (cfg_valid_i && cfg_ready_o) begin
      node_id_q <= cfg_data_i;
    end
  end

  // Front: count bytes into fields, run the CRC, grade the frame.
  cfd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (s_axis_tvalid_i),
    .byte_ready_o (s_axis_tready_o),
    .byte_i       (s_axis_tdata_i),
    .push_o       (push),
    .rec_o        (rec_in),
    .q_full_i     (q_full)
  );

  // Queue of completed frames between the two halves.
  cfd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (rec_in),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_data_o  (rec_out)
  );

  // Back: decide the action against node_id and register the result.
  cfd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .node_id_i     (node_id_q),
    .q_valid_i     (q_valid),
    .q_data_i      (rec_out),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .action_o      (action),
    .frame_valid_o (frame_valid),
    .command_o     (command),
    .target_id_o   (target_id)
  );

  // Pack the result fields, lowest field first.
  assign m_axis_tdata_o = {6'b000000, target_id, command, action};
  assign m_axis_tuser_o = frame_valid;

endmodule

// ----- tb/sv/control_frame_deframer_crc32_top_tb.sv -----
module control_frame_deframer_crc32_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Stop the run long after the slowest legal run would have ended.
  localparam int unsigned CycleLimit   = 300000;
  // Cycles to let pass after the last result before touching node_id or ending.
  localparam int unsigned SettleCycles = 8;
  // Long receiver hold-off used to back the frame queue up into the byte input.
  localparam int unsigned HoldCycles   = 600;
  localparam int unsigned PhaseBytes   = 200;
  localparam int unsigned FrameBytes   = 16;

  // Ways a generated frame is damaged before it goes on the wire.
  typedef enum int {
    FLAW_NONE,
    FLAW_HEADER,
    FLAW_LENGTH,
    FLAW_CHECK,
    FLAW_DELIM,
    FLAW_ANY
  } flaw_e;

  // One expected frame decision as it should leave on m_axis.
  typedef struct {
    cfd_pkg::action_e action;
    logic             frame_valid;
    logic [7:0]       command;
    logic [7:0]       target_id;
  } frame_out_t;

  // Tracks the deframer byte by byte and holds the frame decisions still owed.
  class deframer_tracker;
    logic [7:0]      node_id;
    cfd_pkg::phase_e phase;
    logic [1:0]      idx;
    logic [31:0]     hdr;
    logic [31:0]     chk;
    logic [31:0]     dlm;
    logic [31:0]     crc;
    logic [15:0]     len;
    logic [7:0]      cmd;
    logic [7:0]      id;
    int unsigned     frame_pos;
    frame_out_t      pending_frames[$];
    int unsigned     errors;
    int unsigned     frames_checked;
    int unsigned     frames_good;
    int unsigned     frames_acted;

    function new();
      node_id        = 8'h00;
      phase          = cfd_pkg::PH_HEADER;
      idx            = 2'd0;
      hdr            = '0;
      chk            = '0;
      dlm            = '0;
      crc            = cfd_pkg::CrcInit;
      len            = '0;
      cmd            = '0;
      id             = '0;
      frame_pos      = 0;
      errors         = 0;
      frames_checked = 0;
      frames_good    = 0;
      frames_acted   = 0;
    endfunction

    // Reflected CRC-32, one data bit folded in per shift.
    static function logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
      logic [31:0] r;
      r = c;
      for (int i = 0; i < 8; i++) begin
        r = (r >> 1) ^ ((r[0] ^ b[i]) ? cfd_pkg::CrcPoly : 32'h0);
      end
      return r;
    endfunction

    // Advance the deframer state by one accepted byte; queue a decision at frame end.
    function void absorb_byte(logic [7:0] b);
      logic [31:0] part;
      logic [1:0]  field_last;
      logic        frame_done;
      logic        to_me;
      logic        to_any;
      frame_out_t  res;
      part       = {24'h0, b} << (8 * idx);
      frame_done = 1'b0;
      case (phase)
        cfd_pkg::PH_HEADER:  hdr = (idx == 2'd0) ? part : (hdr | part);
        cfd_pkg::PH_COMMAND: cmd = b;
        cfd_pkg::PH_LENGTH:  len = (idx == 2'd0) ? {b, 8'h00} : (len | {8'h00, b});
        cfd_pkg::PH_ID:      id = b;
        cfd_pkg::PH_CHECK:   chk = (idx == 2'd0) ? part : (chk | part);
        default:             dlm = (idx == 2'd0) ? part : (dlm | part);
      endcase
      if (phase < cfd_pkg::PH_CHECK) crc = crc_step(crc, b);
      case (phase)
        cfd_pkg::PH_COMMAND, cfd_pkg::PH_ID: field_last = 2'd0;
        cfd_pkg::PH_LENGTH:                  field_last = 2'd1;
        default:                             field_last = 2'd3;
      endcase
      if (idx == field_last) begin
        idx = 2'd0;
        if (phase == cfd_pkg::PH_DELIM) begin
          phase      = cfd_pkg::PH_HEADER;
          frame_done = 1'b1;
        end else begin
          phase = cfd_pkg::phase_e'(phase + 3'd1);
        end
      end else begin
        idx = idx + 2'd1;
      end
      frame_pos = frame_done ? 0 : frame_pos + 1;
      if (frame_done) begin
        res.frame_valid = (hdr == cfd_pkg::HeaderPattern) &&
                          (dlm == cfd_pkg::DelimPattern) &&
                          (len == cfd_pkg::LengthExpect) && (chk == ~crc);
        to_me  = (id == node_id);
        to_any = to_me || (id == cfd_pkg::BroadcastId);
        res.action = cfd_pkg::ACT_NONE;
        if (res.frame_valid) begin
          if (cmd == cfd_pkg::CmdTrigger && to_any) begin
            res.action = cfd_pkg::ACT_TRIGGER;
          end else if (cmd == cfd_pkg::CmdReset && to_any) begin
            res.action = cfd_pkg::ACT_RESET;
          end else if (cmd == cfd_pkg::CmdQuery && to_me) begin
            res.action = cfd_pkg::ACT_ACK;
          end
        end
        res.command   = cmd;
        res.target_id = id;
        pending_frames.push_back(res);
        crc = cfd_pkg::CrcInit;
      end
    endfunction

    // Compare one accepted m_axis transaction with the oldest owed decision.
    function void check_frame_result(logic [23:0] data, logic user);
      frame_out_t want;
      if (pending_frames.size() == 0) begin
        $display("%0t: result with none expected, tdata=%h tuser=%b", $time, data, user);
        errors++;
        return;
      end
      want = pending_frames.pop_front();
      frames_checked++;
      if (want.frame_valid) frames_good++;
      if (want.action != cfd_pkg::ACT_NONE) frames_acted++;
      if (data[1:0] !== want.action) begin
        $display("%0t: action expected %0d actual %0d", $time, want.action, data[1:0]);
        errors++;
      end
      if (data[9:2] !== want.command) begin
        $display("%0t: command expected %h actual %h", $time, want.command, data[9:2]);
        errors++;
      end
      if (data[17:10] !== want.target_id) begin
        $display("%0t: target_id expected %h actual %h", $time, want.target_id, data[17:10]);
        errors++;
      end
      if (data[23:18] !== 6'h00) begin
        $display("%0t: tdata pad expected 00 actual %h", $time, data[23:18]);
        errors++;
      end
      if (user !== want.frame_valid) begin
        $display("%0t: frame_valid expected %b actual %b", $time, want.frame_valid, user);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_data;

  deframer_tracker tracker;
  int unsigned     cycle_count = 0;
  int unsigned     bytes_sent  = 0;
  // Idle patterns per side, switched between phases by the main sequence.
  bit              tx_gaps     = 1'b1;
  bit              rx_gaps     = 1'b1;
  // Raised by the main sequence; the receiver turns it into a long hold-off.
  bit              hold_req    = 1'b0;
  int unsigned     holds_done  = 0;

  control_frame_deframer_crc32_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Offer one byte, optionally after a random gap, and hold it until accepted.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = tx_gaps ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    tracker.absorb_byte(b);
    bytes_sent++;
  endtask

  // Build a frame with a correct checksum, damage it as asked, and send it.
  task automatic send_frame(input logic [7:0] cmd, input logic [7:0] id, input flaw_e flaw);
    logic [7:0]  f [FrameBytes];
    logic [31:0] c;
    int unsigned k;
    f = '{8'hEE, 8'hAA, 8'hEE, 8'hAA, cmd, 8'h00, 8'h01, id,
          8'h00, 8'h00, 8'h00, 8'h00, 8'hAE, 8'hAE, 8'hAE, 8'hAE};
    c = cfd_pkg::CrcInit;
    for (int i = 0; i < 8; i++) c = deframer_tracker::crc_step(c, f[i]);
    c = ~c;
    f[8]  = c[7:0];
    f[9]  = c[15:8];
    f[10] = c[23:16];
    f[11] = c[31:24];
    case (flaw)
      FLAW_HEADER: k = $urandom_range(0, 3);
      FLAW_LENGTH: k = $urandom_range(5, 6);
      FLAW_CHECK:  k = $urandom_range(8, 11);
      FLAW_DELIM:  k = $urandom_range(12, 15);
      default:     k = $urandom_range(0, 15);
    endcase
    if (flaw == FLAW_ANY) begin
      f[k] = 8'($urandom);
    end else if (flaw != FLAW_NONE) begin
      f[k] = f[k] ^ 8'($urandom_range(1, 255));
    end
    for (int i = 0; i < FrameBytes; i++) send_byte(f[i]);
  endtask

  // Random garbage that slips the byte count, then padding back to a frame boundary.
  task automatic send_noise();
    int unsigned n;
    n = $urandom_range(1, 24);
    repeat (n) send_byte(8'($urandom));
    while (tracker.frame_pos != 0) send_byte(8'($urandom));
  endtask

  // Drop valid and wait until every owed decision has arrived, then let the block settle.
  task automatic settle_outputs();
    s_axis_tvalid <= 1'b0;
    while (tracker.pending_frames.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Write node_id; callers make sure the block is idle first.
  task automatic write_node_id(input logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk_i); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    tracker.node_id = v;
  endtask

  // Random mix: mostly well-formed frames aimed at this node or broadcast.
  task automatic run_phase();
    int unsigned start;
    int unsigned r;
    logic [7:0]  cmd;
    logic [7:0]  id;
    flaw_e       flaw;
    start = bytes_sent;
    while (bytes_sent - start < PhaseBytes) begin
      if ($urandom_range(0, 9) == 0) begin
        send_noise();
      end else begin
        r = $urandom_range(0, 7);
        case (r)
          0, 1:    cmd = cfd_pkg::CmdTrigger;
          2, 3:    cmd = cfd_pkg::CmdReset;
          4, 5:    cmd = cfd_pkg::CmdQuery;
          default: cmd = 8'($urandom);
        endcase
        r = $urandom_range(0, 3);
        case (r)
          0:       id = cfd_pkg::BroadcastId;
          1, 2:    id = tracker.node_id;
          default: id = 8'($urandom);
        endcase
        flaw = ($urandom_range(0, 9) < 6) ? FLAW_NONE : flaw_e'($urandom_range(1, 5));
        send_frame(cmd, id, flaw);
      end
    end
  endtask

  // Receiver: random tready gaps per transaction, plus the requested long hold-offs.
  initial begin
    int unsigned wait_cycles;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    wait_cycles = 0;
    forever begin
      if (wait_cycles > 0) begin
        m_axis_tready <= 1'b0;
        repeat (wait_cycles) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
      tracker.check_frame_result(m_axis_tdata, m_axis_tuser);
      if (hold_req) begin
        hold_req    = 1'b0;
        holds_done++;
        wait_cycles = HoldCycles;
      end else begin
        wait_cycles = rx_gaps ? $urandom_range(0, 15) : 0;
      end
    end
  end

  initial begin
    logic [7:0] node_set [5];
    tracker       = new();
    rst_ni        = 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 8'h00;
    cfg_valid     <= 1'b0;
    cfg_data      <= 8'h00;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: an addressed query that must be acknowledged, then an all-ones frame.
    write_node_id(8'hA5);
    send_frame(cfd_pkg::CmdQuery, 8'hA5, FLAW_NONE);
    for (int i = 0; i < FrameBytes; i++) send_byte(8'hFF);
    settle_outputs();

    // Random phases over node_id extremes and random addresses, with varied idling.
    node_set = '{8'h00, 8'hFF, 8'h01, 8'($urandom), 8'($urandom)};
    for (int p = 0; p < 5; p++) begin
      write_node_id(node_set[p]);
      tx_gaps = (p == 0) || (p == 2) || (p == 4);
      rx_gaps = (p == 0) || (p == 3) || (p == 4);
      // Back the queue up into the byte input twice during the run.
      hold_req = (p == 1) || (p == 4);
      run_phase();
      settle_outputs();
    end

    $display("Drove %0d bytes, checked %0d frames: %0d well-formed, %0d with an action.",
             bytes_sent, tracker.frames_checked, tracker.frames_good, tracker.frames_acted);
    $display("Covered node ids 00/FF/01 plus two random, %0d long output stalls.",
             holds_done);
    if (tracker.errors == 0 && tracker.pending_frames.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/cfd_pkg.sv
sv/cfd_front.sv
sv/cfd_queue.sv
sv/cfd_back.sv
sv/control_frame_deframer_crc32_top.sv
tb/sv/control_frame_deframer_crc32_top_tb.sv
